// ===== rtl/mtep_pkg.sv =====
`timescale 1ns / 1ps

package mtep_pkg;

  // Parse phases of the track walker
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_DELTA   = 3'd1,
    PH_STATUS  = 3'd2,
    PH_NOTE    = 3'd3,
    PH_VEL     = 3'd4,
    PH_OTHER   = 3'd5,
    PH_ENDPEND = 3'd6,
    PH_HALT    = 3'd7
  } phase_t;

  // Result kinds
  localparam logic [2:0] KIND_NOTE_OFF  = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON   = 3'd1;
  localparam logic [2:0] KIND_OTHER     = 3'd2;
  localparam logic [2:0] KIND_TRACK_END = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_BAD_HEADER  = 2'd1;
  localparam logic [1:0] ERR_BAD_TRACK   = 2'd2;
  localparam logic [1:0] ERR_BAD_NOTE    = 2'd3;

  // Chunk magics and header layout
  localparam logic [31:0] MAGIC_HEAD  = 32'h4d54_6864;
  localparam logic [31:0] MAGIC_TRACK = 32'h4d54_726b;
  localparam logic [31:0] HEAD_LEN    = 32'd6;

  localparam logic [4:0] POS_HEAD_MAGIC  = 5'd3;
  localparam logic [4:0] POS_HEAD_LEN    = 5'd7;
  localparam logic [4:0] POS_TRACK_MAGIC = 5'd17;
  localparam logic [4:0] POS_TRACK_LEN   = 5'd21;

  // Status types that carry a note and a velocity
  localparam logic [3:0] ST_NOTE_OFF = 4'd8;
  localparam logic [3:0] ST_NOTE_ON  = 4'd9;

  localparam logic [1:0] DELTA_LAST_GROUP = 2'd3;

endpackage

// ===== rtl/midi_track_event_parser_top.sv =====
`timescale 1ns / 1ps
// A result is registered; it shows on the output in the cycle after its byte is accepted.
// One byte per cycle unless stalled; the output register refills in the cycle it is taken.
// A byte is taken whenever the result register is empty or being read in that cycle.
// Reset (rst, synchronous, active high) returns the parser to the header phase at position
// zero and empties the result register; restart on a byte does the same for parsing state.
module midi_track_event_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [27:0] delta_time,
  output logic [3:0]  status_type,
  output logic [6:0]  note_number,
  output logic [6:0]  note_velocity,
  output logic [7:0]  other_data,
  output logic [1:0]  error_code
);
  import mtep_pkg::*;

  // Parsing state
  phase_t      phase;
  phase_t      phase_next;
  logic [4:0]  header_position;
  logic [31:0] word_shift;
  logic [31:0] bytes_remaining;
  logic [27:0] delta_accumulator;
  logic [1:0]  delta_group_count;
  logic [3:0]  held_status;
  logic [6:0]  held_note;

  // Restart-adjusted view of the control state
  phase_t      cur_phase;
  logic [4:0]  cur_pos;
  logic [31:0] cur_shift;

  logic [31:0] shift_new;
  logic [31:0] remaining_dec;
  logic        accept;

  // Result register inputs
  logic        res_load;
  logic [2:0]  res_kind;
  logic [27:0] res_delta;
  logic [3:0]  res_status;
  logic [6:0]  res_note;
  logic [6:0]  res_vel;
  logic [7:0]  res_other;
  logic [1:0]  res_err;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign cur_phase     = restart ? PH_HEADER : phase;
  assign cur_pos       = restart ? 5'd0 : header_position;
  assign cur_shift     = restart ? 32'd0 : word_shift;
  assign shift_new     = {cur_shift[23:0], data_byte};
  assign remaining_dec = (bytes_remaining != 32'd0) ? bytes_remaining - 32'd1
                                                    : bytes_remaining;

  // Next phase
  always_comb begin
    phase_next = cur_phase;
    case (cur_phase)
      PH_HEADER: begin
        if ((cur_pos == POS_HEAD_MAGIC && shift_new != MAGIC_HEAD) ||
            (cur_pos == POS_HEAD_LEN && shift_new != HEAD_LEN) ||
            (cur_pos == POS_TRACK_MAGIC && shift_new != MAGIC_TRACK)) begin
          phase_next = PH_HALT;
        end else if (cur_pos >= POS_TRACK_LEN) begin
          phase_next = (shift_new == 32'd0) ? PH_HALT : PH_DELTA;
        end
      end
      PH_DELTA: begin
        if (!data_byte[7] || delta_group_count == DELTA_LAST_GROUP) begin
          phase_next = PH_STATUS;
        end
      end
      PH_STATUS: begin
        phase_next = (data_byte[7:4] inside {ST_NOTE_OFF, ST_NOTE_ON}) ? PH_NOTE : PH_OTHER;
      end
      PH_NOTE: begin
        phase_next = data_byte[7] ? PH_HALT : PH_VEL;
      end
      PH_VEL: begin
        if (data_byte[7]) begin
          phase_next = PH_HALT;
        end else begin
          phase_next = (remaining_dec == 32'd0) ? PH_ENDPEND : PH_DELTA;
        end
      end
      PH_OTHER: begin
        phase_next = (remaining_dec == 32'd0) ? PH_ENDPEND : PH_DELTA;
      end
      PH_ENDPEND: phase_next = PH_HALT;
      PH_HALT:    phase_next = PH_HALT;
      default:    phase_next = PH_HALT;
    endcase
  end

  // Result for the current byte
  always_comb begin
    res_load   = 1'b0;
    res_kind   = KIND_NOTE_OFF;
    res_delta  = '0;
    res_status = '0;
    res_note   = '0;
    res_vel    = '0;
    res_other  = '0;
    res_err    = ERR_NONE;
    case (cur_phase)
      PH_HEADER: begin
        if ((cur_pos == POS_HEAD_MAGIC && shift_new != MAGIC_HEAD) ||
            (cur_pos == POS_HEAD_LEN && shift_new != HEAD_LEN)) begin
          res_load = 1'b1;
          res_kind = KIND_ERROR;
          res_err  = ERR_BAD_HEADER;
        end else if (cur_pos == POS_TRACK_MAGIC && shift_new != MAGIC_TRACK) begin
          res_load = 1'b1;
          res_kind = KIND_ERROR;
          res_err  = ERR_BAD_TRACK;
        end else if (cur_pos >= POS_TRACK_LEN && shift_new == 32'd0) begin
          res_load = 1'b1;
          res_kind = KIND_TRACK_END;
        end
      end
      PH_NOTE: begin
        if (data_byte[7]) begin
          res_load = 1'b1;
          res_kind = KIND_ERROR;
          res_err  = ERR_BAD_NOTE;
        end
      end
      PH_VEL: begin
        res_load = 1'b1;
        if (data_byte[7]) begin
          res_kind = KIND_ERROR;
          res_err  = ERR_BAD_NOTE;
        end else begin
          res_kind   = (held_status == ST_NOTE_ON) ? KIND_NOTE_ON : KIND_NOTE_OFF;
          res_delta  = delta_accumulator;
          res_status = held_status;
          res_note   = held_note;
          res_vel    = data_byte[6:0];
        end
      end
      PH_OTHER: begin
        res_load   = 1'b1;
        res_kind   = KIND_OTHER;
        res_delta  = delta_accumulator;
        res_status = held_status;
        res_other  = data_byte;
      end
      PH_ENDPEND: begin
        res_load = 1'b1;
        res_kind = KIND_TRACK_END;
      end
      default: res_load = 1'b0;
    endcase
  end

  // Control state: phase and header position
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_position <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (cur_phase == PH_HEADER) begin
        header_position <= cur_pos + 5'd1;
      end else begin
        header_position <= cur_pos;
      end
    end
  end

  // Payload state: header word, remaining track bytes, delta and held event fields
  always_ff @(posedge clk) begin
    if (accept) begin
      case (cur_phase)
        PH_HEADER: begin
          word_shift <= shift_new;
          if (cur_pos >= POS_TRACK_LEN) begin
            bytes_remaining   <= shift_new;
            delta_accumulator <= '0;
            delta_group_count <= '0;
          end
        end
        PH_DELTA: begin
          bytes_remaining   <= remaining_dec;
          delta_accumulator <= {delta_accumulator[20:0], data_byte[6:0]};
          if (data_byte[7] && delta_group_count != DELTA_LAST_GROUP) begin
            delta_group_count <= delta_group_count + 2'd1;
          end
        end
        PH_STATUS: begin
          bytes_remaining <= remaining_dec;
          held_status     <= data_byte[7:4];
        end
        PH_NOTE: begin
          bytes_remaining <= remaining_dec;
          held_note       <= data_byte[6:0];
        end
        PH_VEL, PH_OTHER: begin
          bytes_remaining   <= remaining_dec;
          delta_accumulator <= '0;
          delta_group_count <= '0;
        end
        default: bytes_remaining <= bytes_remaining;
      endcase
    end
  end

  // Result register: hold while stalled, load on a result-bearing item
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= accept && res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_load) begin
      kind          <= res_kind;
      delta_time    <= res_delta;
      status_type   <= res_status;
      note_number   <= res_note;
      note_velocity <= res_vel;
      other_data    <= res_other;
      error_code    <= res_err;
    end
  end

  // Checks
  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    (accept && res_load && (res_kind == KIND_ERROR || res_kind == KIND_TRACK_END))
      |=> phase == PH_HALT)
    else $error("error or track end did not halt the parser");

  a_header_pos_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HEADER) |-> header_position <= POS_TRACK_LEN)
    else $error("header position ran past the track length field");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  a_note_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_NOTE_OFF) |-> status_type == ST_NOTE_OFF)
    else $error("note off result with wrong status");

  a_note_on_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_NOTE_ON) |-> status_type == ST_NOTE_ON)
    else $error("note on result with wrong status");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(delta_time)))
    else $error("stalled result changed");

endmodule
